// File: hdl/assert_macros.svh
// Assertion helpers for the hexahedron volume core.
// HV_ASSERT_IMPL checks a same-cycle implication, HV_ASSERT_NEXT a next-cycle one.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define HV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

`define HV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define HV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define HV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/hexvol_pkg.sv
package hexvol_pkg;

	// Input geometry
	localparam int COORD_BITS  = 16;
	localparam int SLOT_W      = 16;
	localparam int NUM_AXES    = 3;
	localparam int CORNER_W    = SLOT_W * NUM_AXES;
	localparam int NUM_CORNERS = 8;
	localparam int NUM_FACES   = 6;
	localparam int IN_W        = CORNER_W * NUM_CORNERS;

	// Result fields
	localparam int TWELVE_W = 56;
	localparam int VOL_W    = 53;
	localparam int OUT_W    = ((TWELVE_W + VOL_W + 7) / 8) * 8;
	localparam int PAD_W    = OUT_W - TWELVE_W - VOL_W;

	// Face flux datapath widths
	localparam int SUM_W   = COORD_BITS + 2;   // sum of four corners
	localparam int DIFF_W  = COORD_BITS + 1;   // diagonal difference
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int DOT_W   = SUM_W + CROSS_W;
	localparam int FACE_W  = DOT_W + 2;        // three dot terms
	localparam int TOTAL_W = FACE_W + 3;       // six faces

	// Divide by twelve: shift by two, then multiply by reciprocal of three
	localparam int MAG_W      = TWELVE_W - 2;
	localparam int HALF_W     = MAG_W / 2;
	localparam int FULL_W     = 2 * MAG_W;
	localparam int DIV3_SHIFT = MAG_W + 1;
	localparam logic [MAG_W+1:0] DIV3_NUM =
		((MAG_W + 2)'(1) << DIV3_SHIFT) + (MAG_W + 2)'(1);
	localparam logic [MAG_W-1:0] DIV3_RECIP = MAG_W'(DIV3_NUM / 3);

	// Pipeline depth
	localparam int NUM_STAGES = 9;

	// Corner positions within a face, parameterized (s,t) with s x t outward
	localparam int P00 = 0;
	localparam int P10 = 1;
	localparam int P01 = 2;
	localparam int P11 = 3;

	typedef logic [2:0] corner_idx_t;

	localparam corner_idx_t FACE_CORNERS [NUM_FACES][4] = '{
		'{3'd0, 3'd4, 3'd2, 3'd6},   // x low side
		'{3'd1, 3'd3, 3'd5, 3'd7},   // x high side
		'{3'd0, 3'd1, 3'd4, 3'd5},   // y low side
		'{3'd2, 3'd6, 3'd3, 3'd7},   // y high side
		'{3'd0, 3'd2, 3'd1, 3'd3},   // z low side
		'{3'd4, 3'd5, 3'd6, 3'd7}    // z high side
	};

	typedef struct packed {
		logic signed [SUM_W-1:0] x;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] z;
	} sum_vec_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] x;
		logic signed [DIFF_W-1:0] y;
		logic signed [DIFF_W-1:0] z;
	} diff_vec_t;

	typedef struct packed {
		sum_vec_t  s;
		diff_vec_t d1;
		diff_vec_t d2;
	} face_geom_t;

	typedef logic signed [FACE_W-1:0] face_flux_t;

	// Per-stage register enables
	typedef struct packed {
		logic [NUM_STAGES:1] load;
	} pipe_ctrl_t;

endpackage

// File: hdl/hexvol_flux.sv
// Flux of the position field through one bilinear face, times eight:
// S . (D1 x D2), S the corner sum, D1 and D2 the face diagonals.
module hexvol_flux (
	input  logic                   clk,
	input  hexvol_pkg::pipe_ctrl_t ctrl,
	input  hexvol_pkg::face_geom_t geom_s1,
	output hexvol_pkg::face_flux_t flux_s4
);

	logic signed [hexvol_pkg::PROD_W-1:0]  pr_s2 [6];
	hexvol_pkg::sum_vec_t                  sv_s2;
	logic signed [hexvol_pkg::CROSS_W-1:0] cr_x;
	logic signed [hexvol_pkg::CROSS_W-1:0] cr_y;
	logic signed [hexvol_pkg::CROSS_W-1:0] cr_z;
	logic signed [hexvol_pkg::DOT_W-1:0]   dt_s3 [3];
	logic signed [hexvol_pkg::PROD_W-1:0]  d1x, d1y, d1z, d2x, d2y, d2z;

	// Diagonals widened to product width
	assign d1x = hexvol_pkg::PROD_W'($signed(geom_s1.d1.x));
	assign d1y = hexvol_pkg::PROD_W'($signed(geom_s1.d1.y));
	assign d1z = hexvol_pkg::PROD_W'($signed(geom_s1.d1.z));
	assign d2x = hexvol_pkg::PROD_W'($signed(geom_s1.d2.x));
	assign d2y = hexvol_pkg::PROD_W'($signed(geom_s1.d2.y));
	assign d2z = hexvol_pkg::PROD_W'($signed(geom_s1.d2.z));

	// Stage 2: cross product partial terms
	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			pr_s2[0] <= d1y * d2z;
			pr_s2[1] <= d1z * d2y;
			pr_s2[2] <= d1z * d2x;
			pr_s2[3] <= d1x * d2z;
			pr_s2[4] <= d1x * d2y;
			pr_s2[5] <= d1y * d2x;
			sv_s2    <= geom_s1.s;
		end
	end

	// Cross product components
	always_comb begin
		cr_x = hexvol_pkg::CROSS_W'(pr_s2[0]) - hexvol_pkg::CROSS_W'(pr_s2[1]);
		cr_y = hexvol_pkg::CROSS_W'(pr_s2[2]) - hexvol_pkg::CROSS_W'(pr_s2[3]);
		cr_z = hexvol_pkg::CROSS_W'(pr_s2[4]) - hexvol_pkg::CROSS_W'(pr_s2[5]);
	end

	// Stage 3: dot product terms
	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			dt_s3[0] <= hexvol_pkg::DOT_W'($signed(sv_s2.x)) * hexvol_pkg::DOT_W'(cr_x);
			dt_s3[1] <= hexvol_pkg::DOT_W'($signed(sv_s2.y)) * hexvol_pkg::DOT_W'(cr_y);
			dt_s3[2] <= hexvol_pkg::DOT_W'($signed(sv_s2.z)) * hexvol_pkg::DOT_W'(cr_z);
		end
	end

	// Stage 4: face total
	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			flux_s4 <= hexvol_pkg::FACE_W'(dt_s3[0]) + hexvol_pkg::FACE_W'(dt_s3[1])
				+ hexvol_pkg::FACE_W'(dt_s3[2]);
		end
	end

endmodule

// File: hdl/hexvol_div12.sv
// Signed divide by twelve, truncating toward zero.
// |x| >> 2 is multiplied by a rounded-up reciprocal of three in four
// half-width partial products, then the sign is put back.
module hexvol_div12 (
	input  logic                                clk,
	input  hexvol_pkg::pipe_ctrl_t              ctrl,
	input  logic signed [hexvol_pkg::TWELVE_W-1:0] twelve_s5,
	output logic signed [hexvol_pkg::TWELVE_W-1:0] twelve_s9,
	output logic signed [hexvol_pkg::VOL_W-1:0]    volume_s9
);

	localparam int HW = hexvol_pkg::HALF_W;

	logic [hexvol_pkg::TWELVE_W-1:0]        mag_abs;
	logic                                   neg_s6, neg_s7, neg_s8;
	logic [hexvol_pkg::MAG_W-1:0]           mag_s6;
	logic signed [hexvol_pkg::TWELVE_W-1:0] tw_s6, tw_s7, tw_s8;
	logic [2*HW-1:0]                        pp_ll_s7, pp_lh_s7, pp_hl_s7, pp_hh_s7;
	logic [hexvol_pkg::FULL_W-1:0]          full_prod;
	logic [hexvol_pkg::VOL_W-1:0]           quo_s8;
	logic [HW-1:0]                          rc_lo, rc_hi;

	assign rc_lo = hexvol_pkg::DIV3_RECIP[HW-1:0];
	assign rc_hi = hexvol_pkg::DIV3_RECIP[2*HW-1:HW];

	// Magnitude of the twelvefold value
	assign mag_abs = twelve_s5[hexvol_pkg::TWELVE_W-1]
		? (~twelve_s5 + hexvol_pkg::TWELVE_W'(1)) : twelve_s5;

	// Stage 6: sign and quarter magnitude
	always_ff @(posedge clk) begin
		if (ctrl.load[6]) begin
			neg_s6 <= twelve_s5[hexvol_pkg::TWELVE_W-1];
			mag_s6 <= mag_abs[hexvol_pkg::TWELVE_W-1:2];
			tw_s6  <= twelve_s5;
		end
	end

	// Stage 7: partial products of the reciprocal multiply
	always_ff @(posedge clk) begin
		if (ctrl.load[7]) begin
			pp_ll_s7 <= (2*HW)'(mag_s6[HW-1:0])    * (2*HW)'(rc_lo);
			pp_lh_s7 <= (2*HW)'(mag_s6[HW-1:0])    * (2*HW)'(rc_hi);
			pp_hl_s7 <= (2*HW)'(mag_s6[2*HW-1:HW]) * (2*HW)'(rc_lo);
			pp_hh_s7 <= (2*HW)'(mag_s6[2*HW-1:HW]) * (2*HW)'(rc_hi);
			neg_s7   <= neg_s6;
			tw_s7    <= tw_s6;
		end
	end

	// Recombine and keep the quotient bits
	assign full_prod = (hexvol_pkg::FULL_W'(pp_hh_s7) << (2*HW))
		+ ((hexvol_pkg::FULL_W'(pp_lh_s7) + hexvol_pkg::FULL_W'(pp_hl_s7)) << HW)
		+ hexvol_pkg::FULL_W'(pp_ll_s7);

	// Stage 8: unsigned quotient
	always_ff @(posedge clk) begin
		if (ctrl.load[8]) begin
			quo_s8 <= full_prod[hexvol_pkg::DIV3_SHIFT +: hexvol_pkg::VOL_W];
			neg_s8 <= neg_s7;
			tw_s8  <= tw_s7;
		end
	end

	// Stage 9: restore sign
	always_ff @(posedge clk) begin
		if (ctrl.load[9]) begin
			volume_s9 <= neg_s8 ? $signed(~quo_s8 + hexvol_pkg::VOL_W'(1)) : $signed(quo_s8);
			twelve_s9 <= tw_s8;
		end
	end

endmodule

// File: hdl/hexahedron_volume_core.sv
// Exact volume of a trilinear hexahedral cell. Each input transaction carries
// the eight corners (x, y, z two's complement coordinates, corner k with bit 0
// selecting the x side, bit 1 the y side, bit 2 the z side); each output
// transaction carries twelve times the signed volume, exact, and the volume
// itself truncated toward zero, both with three times the coordinate fraction
// bits. The volume is taken as the flux of the position field through the six
// bilinear faces, each face contributing (corner sum) . (diag1 x diag2).
// One cell per clock is accepted and delivered while the output does not stall;
// from input to output the data pass the nine register stages of the multiplier pipeline
// (face geometry, cross products, dot products, face sums, cell sum, magnitude,
// reciprocal partial products, quotient, sign). Stalls on the output hold
// each stage independently, so bubbles are squeezed out while the output waits.
module hexahedron_volume_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// corner_0 .. corner_7, 48 bits each, corner_0 lowest
	input  logic [hexvol_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// twelve_volume [55:0], volume [108:56], zero pad above
	output logic [hexvol_pkg::OUT_W-1:0]     m_axis_tdata
);

`include "assert_macros.svh"

	localparam int NS = hexvol_pkg::NUM_STAGES;

	logic [NS:1]                               vld_q;
	logic [NS:1]                               rdy;
	hexvol_pkg::pipe_ctrl_t                    ctrl;
	logic signed [hexvol_pkg::COORD_BITS-1:0]  crd [hexvol_pkg::NUM_CORNERS][3];
	logic signed [hexvol_pkg::SUM_W-1:0]       fsum [hexvol_pkg::NUM_FACES][3];
	logic signed [hexvol_pkg::DIFF_W-1:0]      fd1 [hexvol_pkg::NUM_FACES][3];
	logic signed [hexvol_pkg::DIFF_W-1:0]      fd2 [hexvol_pkg::NUM_FACES][3];
	hexvol_pkg::face_geom_t                    geom_d [hexvol_pkg::NUM_FACES];
	hexvol_pkg::face_geom_t                    geom_s1 [hexvol_pkg::NUM_FACES];
	hexvol_pkg::face_flux_t                    flux_s4 [hexvol_pkg::NUM_FACES];
	logic signed [hexvol_pkg::TOTAL_W-1:0]     total;
	logic signed [hexvol_pkg::TWELVE_W-1:0]    twelve_s5;
	logic signed [hexvol_pkg::TWELVE_W-1:0]    twelve_s9;
	logic signed [hexvol_pkg::VOL_W-1:0]       volume_s9;

	// Per-stage ready chain: a stage loads when empty or when the next one moves
	always_comb begin
		rdy[NS] = !vld_q[NS] || m_axis_tready;
		for (int k = NS - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign ctrl.load     = rdy;
	assign s_axis_tready = rdy[1];
	assign m_axis_tvalid = vld_q[NS];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Unpack coordinates; slot bits above COORD_BITS are ignored
	always_comb begin
		for (int n = 0; n < hexvol_pkg::NUM_CORNERS; n++) begin
			for (int a = 0; a < hexvol_pkg::NUM_AXES; a++) begin
				crd[n][a] = s_axis_tdata[n*hexvol_pkg::CORNER_W + a*hexvol_pkg::SLOT_W
					+: hexvol_pkg::COORD_BITS];
			end
		end
	end

	// Face corner sums and diagonals
	always_comb begin
		for (int f = 0; f < hexvol_pkg::NUM_FACES; f++) begin
			for (int a = 0; a < hexvol_pkg::NUM_AXES; a++) begin
				fsum[f][a] =
					hexvol_pkg::SUM_W'(crd[hexvol_pkg::FACE_CORNERS[f][hexvol_pkg::P00]][a])
					+ hexvol_pkg::SUM_W'(crd[hexvol_pkg::FACE_CORNERS[f][hexvol_pkg::P10]][a])
					+ hexvol_pkg::SUM_W'(crd[hexvol_pkg::FACE_CORNERS[f][hexvol_pkg::P01]][a])
					+ hexvol_pkg::SUM_W'(crd[hexvol_pkg::FACE_CORNERS[f][hexvol_pkg::P11]][a]);
				fd1[f][a] =
					hexvol_pkg::DIFF_W'(crd[hexvol_pkg::FACE_CORNERS[f][hexvol_pkg::P11]][a])
					- hexvol_pkg::DIFF_W'(crd[hexvol_pkg::FACE_CORNERS[f][hexvol_pkg::P00]][a]);
				fd2[f][a] =
					hexvol_pkg::DIFF_W'(crd[hexvol_pkg::FACE_CORNERS[f][hexvol_pkg::P01]][a])
					- hexvol_pkg::DIFF_W'(crd[hexvol_pkg::FACE_CORNERS[f][hexvol_pkg::P10]][a]);
			end
			geom_d[f].s.x  = fsum[f][0];
			geom_d[f].s.y  = fsum[f][1];
			geom_d[f].s.z  = fsum[f][2];
			geom_d[f].d1.x = fd1[f][0];
			geom_d[f].d1.y = fd1[f][1];
			geom_d[f].d1.z = fd1[f][2];
			geom_d[f].d2.x = fd2[f][0];
			geom_d[f].d2.y = fd2[f][1];
			geom_d[f].d2.z = fd2[f][2];
		end
	end

	// Stage 1: face geometry
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int f = 0; f < hexvol_pkg::NUM_FACES; f++) begin
				geom_s1[f] <= geom_d[f];
			end
		end
	end

	// Stages 2..4: one flux unit per face
	for (genvar f = 0; f < hexvol_pkg::NUM_FACES; f++) begin : g_face
		hexvol_flux u_flux (
			.clk     (clk),
			.ctrl    (ctrl),
			.geom_s1 (geom_s1[f]),
			.flux_s4 (flux_s4[f])
		);
	end

	// Sum over the closed surface is twice the twelvefold volume
	always_comb begin
		total = '0;
		for (int f = 0; f < hexvol_pkg::NUM_FACES; f++) begin
			total = total + hexvol_pkg::TOTAL_W'(flux_s4[f]);
		end
	end

	// Stage 5: twelvefold volume
	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			twelve_s5 <= total[1 +: hexvol_pkg::TWELVE_W];
		end
	end

	// Stages 6..9: divide by twelve
	hexvol_div12 u_div12 (
		.clk       (clk),
		.ctrl      (ctrl),
		.twelve_s5 (twelve_s5),
		.twelve_s9 (twelve_s9),
		.volume_s9 (volume_s9)
	);

	assign m_axis_tdata = {hexvol_pkg::PAD_W'(0), volume_s9, twelve_s9};

	// An empty output stage never blocks the input side
	`HV_ASSERT_IMPL(a_empty_out_ready, clk, arst_n, !vld_q[NS], s_axis_tready)

	// An accepted transaction always lands in stage 1
	`HV_ASSERT_NEXT(a_accept_fills, clk, arst_n, s_axis_tvalid && s_axis_tready, vld_q[1])

	// A stalled mid stage keeps its item
	`HV_ASSERT_NEXT(a_mid_stall_holds, clk, arst_n, vld_q[5] && !rdy[5],
		vld_q[5] && $stable(twelve_s5))

	// Nonzero quotient carries the sign of the twelvefold value
	`HV_ASSERT_IMPL(a_sign_match, clk, arst_n, m_axis_tvalid && (volume_s9 != '0),
		volume_s9[hexvol_pkg::VOL_W-1] == twelve_s9[hexvol_pkg::TWELVE_W-1])

endmodule

// File: tb/sv/hexahedron_volume_check.sv
// Watches both stream channels, predicts the volume of every accepted cell and
// compares each returned transaction with the oldest prediction.
module hexahedron_volume_check
	import hexvol_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_W-1:0]        s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_W-1:0]       m_axis_tdata,
	output int unsigned            mismatches,
	output int unsigned            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 20;

	// Same layout as m_axis_tdata, highest field first
	typedef struct packed {
		logic [PAD_W-1:0]           pad;
		logic signed [VOL_W-1:0]    volume;
		logic signed [TWELVE_W-1:0] twelve_volume;
	} cell_volume_t;

	cell_volume_t expected_volumes [$];
	int unsigned  mismatch_count = 0;
	int unsigned  queued = 0;
	int unsigned  volumes_checked = 0;

	assign mismatches  = mismatch_count;
	assign outstanding = queued;

	// Exact volume by the 3x3x3 Simpson rule, which integrates the Jacobian
	// determinant exactly. Columns are four times the reference derivatives and
	// the weights are 1-4-1, so the total is 1152 times the twelvefold volume.
	function automatic cell_volume_t predict_volume(input logic [IN_W-1:0] corners);
		logic signed [127:0]          pos [NUM_CORNERS][NUM_AXES];
		logic signed [127:0]          jac [NUM_AXES][NUM_AXES];
		logic signed [127:0]          acc, det, w, twelve;
		logic signed [COORD_BITS-1:0] coord;
		int                           node [NUM_AXES];
		int                           n, a, d, e, gx, gy, gz;
		cell_volume_t                 res;
		for (n = 0; n < NUM_CORNERS; n++)
			for (a = 0; a < NUM_AXES; a++) begin
				// bits above COORD_BITS in a slot are ignored
				coord = corners[n * CORNER_W + a * SLOT_W +: COORD_BITS];
				pos[n][a] = coord;
			end
		acc = '0;
		for (gx = 0; gx < 3; gx++)
			for (gy = 0; gy < 3; gy++)
				for (gz = 0; gz < 3; gz++) begin
					node = '{gx, gy, gz};
					for (d = 0; d < NUM_AXES; d++) begin
						for (a = 0; a < NUM_AXES; a++)
							jac[a][d] = '0;
						// edges along direction d, bilinear weights on the doubled grid
						for (n = 0; n < NUM_CORNERS; n++)
							if (!n[d]) begin
								w = 1;
								for (e = 0; e < NUM_AXES; e++)
									if (e != d)
										w = w * (n[e] ? node[e] : 2 - node[e]);
								for (a = 0; a < NUM_AXES; a++)
									jac[a][d] = jac[a][d] + w * (pos[n + (1 << d)][a] - pos[n][a]);
							end
					end
					det = jac[0][0] * (jac[1][1] * jac[2][2] - jac[1][2] * jac[2][1])
						- jac[0][1] * (jac[1][0] * jac[2][2] - jac[1][2] * jac[2][0])
						+ jac[0][2] * (jac[1][0] * jac[2][1] - jac[1][1] * jac[2][0]);
					acc = acc + (gx == 1 ? 4 : 1) * (gy == 1 ? 4 : 1) * (gz == 1 ? 4 : 1) * det;
				end
		twelve = acc / 1152;
		res.pad           = '0;
		res.twelve_volume = twelve[TWELVE_W-1:0];
		// signed division truncates toward zero
		res.volume        = VOL_W'(twelve / 12);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < PRINT_CAP)
			$display("%t mismatch on result %0d: %s got %0d expected %0d",
				$realtime, volumes_checked, what, got, want);
		mismatch_count++;
	endtask

	// Predict on input transactions, compare on output transactions
	always @(posedge clk) begin
		cell_volume_t got, want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_volumes.insert(expected_volumes.size(), predict_volume(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_volumes.size() == 0) begin
					report_mismatch("unexpected result, twelve_volume", got.twelve_volume, 0);
				end else begin
					want = expected_volumes.pop_front();
					if (got.twelve_volume !== want.twelve_volume)
						report_mismatch("twelve_volume", got.twelve_volume, want.twelve_volume);
					if (got.volume !== want.volume)
						report_mismatch("volume", got.volume, want.volume);
					if (got.pad !== want.pad)
						report_mismatch("pad bits", got.pad, want.pad);
				end
				volumes_checked++;
			end
			queued <= expected_volumes.size();
		end
	end

endmodule

// File: tb/sv/hexahedron_volume_core_test.sv
// Drives cells into the volume core, paces the result side and gives the verdict.
module hexahedron_volume_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hexvol_pkg::*;

	localparam int RANDOM_CELLS = 1750;
	localparam int HOLD_AFTER   = 400;    // results taken before the long hold-off
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 2000;   // cycles without any transaction
	localparam int CMIN         = -(2 ** (COORD_BITS - 1));
	localparam int CMAX         = 2 ** (COORD_BITS - 1) - 1;

	// corner n, axis a sits at bits n*48 + a*16
	typedef logic [NUM_CORNERS-1:0][NUM_AXES-1:0][SLOT_W-1:0] cell_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count   = 0;
	int unsigned idle_cycles   = 0;
	int unsigned cells_sent    = 0;
	int unsigned cells_queued  = 0;
	int unsigned volumes_taken = 0;

	hexahedron_volume_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	hexahedron_volume_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Axis-aligned box with optional per-coordinate jitter; negative sides invert it
	function automatic logic [IN_W-1:0] box_cell(input int ox, input int oy, input int oz,
			input int sx, input int sy, input int sz, input int jit);
		cell_t corners;
		int    origin [NUM_AXES];
		int    side [NUM_AXES];
		int    n, a, v;
		origin = '{ox, oy, oz};
		side   = '{sx, sy, sz};
		for (n = 0; n < NUM_CORNERS; n++)
			for (a = 0; a < NUM_AXES; a++) begin
				v = origin[a] + (n[a] ? side[a] : 0);
				if (jit > 0)
					v += int'($urandom_range(0, 2 * jit)) - jit;
				corners[n][a] = SLOT_W'(v);
			end
		return corners;
	endfunction

	// Every coordinate drawn from the range ends and the values around zero
	function automatic logic [IN_W-1:0] extreme_cell();
		cell_t corners;
		int    n, a;
		for (n = 0; n < NUM_CORNERS; n++)
			for (a = 0; a < NUM_AXES; a++)
				case ($urandom_range(0, 4))
					0: corners[n][a] = SLOT_W'(CMIN);
					1: corners[n][a] = SLOT_W'(CMAX);
					2: corners[n][a] = '0;
					3: corners[n][a] = '1;
					default: corners[n][a] = SLOT_W'(1);
				endcase
		return corners;
	endfunction

	function automatic logic [IN_W-1:0] raw_cell();
		logic [IN_W-1:0] corners;
		int              i;
		for (i = 0; i < IN_W / 32; i++)
			corners[i * 32 +: 32] = $urandom;
		return corners;
	endfunction

	// One input transaction, with a random gap ahead of it outside quiet windows
	task automatic send_cell(input logic [IN_W-1:0] corners);
		int unsigned gap;
		gap = 0;
		if (cycle_count[8:7] != 2'b11 && $urandom_range(0, 99) < 25)
			gap = pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= corners;
		do @(posedge clk); while (!s_axis_tready);
		cells_queued++;
	endtask

	// Transaction counters and watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (s_axis_tvalid && s_axis_tready)
			cells_sent <= cells_sent + 1;
		if (m_axis_tvalid && m_axis_tready)
			volumes_taken <= volumes_taken + 1;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction", idle_cycles);
			$display("hexahedron_volume_core_test NOT OK");
			$finish;
		end
	end

	// Result side: random stalls, quiet windows, and one long hold-off
	initial begin
		int unsigned stall_left;
		bit          held;
		stall_left = 0;
		held       = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && volumes_taken >= HOLD_AFTER) begin
				held       = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && cycle_count[9:8] != 2'b01 && $urandom_range(0, 99) < 20) begin
				stall_left = pick_gap();
			end
			if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		cell_t       corners;
		int unsigned i, directed_cells;
		int          lim, jit;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		// degenerate and saturated words
		send_cell('0);
		send_cell('1);
		send_cell({(NUM_CORNERS * NUM_AXES){SLOT_W'(CMAX)}});
		send_cell({(NUM_CORNERS * NUM_AXES){SLOT_W'(CMIN)}});
		send_cell({(IN_W / 4){4'hA}});
		send_cell({(IN_W / 4){4'h5}});
		// unit cube both ways round, full-range cube both ways round
		send_cell(box_cell(0, 0, 0, 1, 1, 1, 0));
		send_cell(box_cell(0, 0, 0, -1, 1, 1, 0));
		send_cell(box_cell(CMIN, CMIN, CMIN, CMAX - CMIN, CMAX - CMIN, CMAX - CMIN, 0));
		send_cell(box_cell(CMAX, CMIN, CMIN, CMIN - CMAX, CMAX - CMIN, CMAX - CMIN, 0));
		// flat cell has zero volume
		send_cell(box_cell(100, 100, 0, 50, 60, 0, 0));
		// top face turned a quarter turn: tangled cell
		corners = box_cell(0, 0, 0, 1000, 1000, 1000, 0);
		corners[4][0] = SLOT_W'(1000);
		corners[4][1] = '0;
		corners[5][0] = SLOT_W'(1000);
		corners[5][1] = SLOT_W'(1000);
		corners[6][0] = '0;
		corners[6][1] = '0;
		corners[7][0] = '0;
		corners[7][1] = SLOT_W'(1000);
		send_cell(corners);
		// one corner collapsed onto the opposite one
		corners = box_cell(-20, 30, -40, 70, 50, 90, 0);
		corners[7] = corners[0];
		send_cell(corners);
		// small skewed cells, positive and mirrored: quotient rounding of both signs
		for (i = 0; i < 3; i++) begin
			send_cell(box_cell(0, 0, 0, 2, 3, 1, 1));
			send_cell(box_cell(0, 0, 0, -2, 3, 1, 1));
		end
		send_cell(extreme_cell());
		send_cell(extreme_cell());
		send_cell(raw_cell());
		directed_cells = cells_queued;

		// random part: jittered boxes at several scales, raw words, extreme corners
		for (i = 0; i < RANDOM_CELLS; i++) begin
			case ($urandom_range(0, 99)) inside
				[0:54]: begin
					case ($urandom_range(0, 3))
						0: lim = 15;
						1: lim = 255;
						2: lim = 4095;
						default: lim = CMAX;
					endcase
					jit = $urandom_range(0, lim / 8);
					send_cell(box_cell(
						int'($urandom_range(0, 2 * lim)) - lim,
						int'($urandom_range(0, 2 * lim)) - lim,
						int'($urandom_range(0, 2 * lim)) - lim,
						int'($urandom_range(0, 2 * lim)) - lim,
						int'($urandom_range(0, 2 * lim)) - lim,
						int'($urandom_range(0, 2 * lim)) - lim,
						jit));
				end
				[55:79]: send_cell(raw_cell());
				default: send_cell(extreme_cell());
			endcase
		end
		s_axis_tvalid <= 1'b0;

		// let the last prediction settle, drain, then give any stray result time to show
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (NUM_STAGES + 4) @(posedge clk);

		$display("cells accepted: %0d (%0d directed: zero, saturated, unit, full range, inverted,",
			cells_sent, directed_cells);
		$display("  flat, tangled, collapsed, skewed); volumes returned: %0d; one %0d-cycle output hold",
			volumes_taken, HOLD_CYCLES);
		if (mismatches == 0 && outstanding == 0)
			$display("hexahedron_volume_core_test OK");
		else
			$display("hexahedron_volume_core_test NOT OK");
		$finish;
	end

endmodule
